// File: rtl/psp_pkg.sv
`timescale 1ns / 1ps

package psp_pkg;

  // datapath widths
  localparam int XW        = 34;  // cordic x / y, 2^-26 m
  localparam int ZW        = 25;  // cordic angle, 2^-16 degree
  localparam int LO_BITS   = 16;  // low half of a cordic value in the gain multiply
  localparam int OP_W      = XW - LO_BITS;
  localparam int GAIN_W    = 31;
  localparam int PROD_W    = OP_W + GAIN_W;
  localparam int ACC_W     = 64;
  localparam int OUT_SHIFT = 44;
  localparam int RW        = ACC_W - OUT_SHIFT;
  localparam int TABLE_LEN = 24;

  // turn constants, 1/256 degree
  localparam logic signed [17:0] HALF_TURN = 18'sd46080;
  localparam logic signed [17:0] FULL_TURN = 18'sd92160;

  // fine angle constants, 2^-16 degree
  localparam logic signed [ZW-1:0] QUARTER_FINE = 25'sd5898240;
  localparam logic signed [ZW-1:0] HALF_FINE    = 25'sd11796480;

  // cordic gain compensation in q30 and rounding bias
  localparam logic signed [GAIN_W-1:0] GAIN_Q30   = 31'sd652032874;
  localparam logic signed [ACC_W-1:0]  ROUND_BIAS = 64'sh0000_0800_0000_0000;

  // arctangent of 2^-i in 2^-16 degree
  localparam logic signed [ZW-1:0] ATAN_FINE [TABLE_LEN] = '{
    25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945, 25'sd234379, 25'sd117304,
    25'sd58666,   25'sd29335,   25'sd14668,  25'sd7334,   25'sd3667,   25'sd1833,
    25'sd917,     25'sd458,     25'sd229,    25'sd115,    25'sd57,     25'sd29,
    25'sd14,      25'sd7,       25'sd4,      25'sd2,      25'sd1,      25'sd0
  };

  // vector handed from cell to cell
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } rot_vec_t;

endpackage

// File: rtl/psp_cordic_cell.sv
`timescale 1ns / 1ps

module psp_cordic_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  psp_pkg::rot_vec_t  vec_i,
  output logic               valid_o,
  output psp_pkg::rot_vec_t  vec_o
);

  logic signed [psp_pkg::XW-1:0] x_in;
  logic signed [psp_pkg::XW-1:0] y_in;
  logic signed [psp_pkg::ZW-1:0] z_in;
  psp_pkg::rot_vec_t             vec_d;
  psp_pkg::rot_vec_t             vec_q;
  logic                          valid_q;

  assign x_in = vec_i.x;
  assign y_in = vec_i.y;
  assign z_in = vec_i.z;

  // one micro-rotation toward zero residual angle
  always_comb begin
    if (z_in >= 0) begin
      vec_d.x = x_in - (y_in >>> IDX);
      vec_d.y = y_in + (x_in >>> IDX);
      vec_d.z = z_in - psp_pkg::ATAN_FINE[IDX];
    end else begin
      vec_d.x = x_in + (y_in >>> IDX);
      vec_d.y = y_in - (x_in >>> IDX);
      vec_d.z = z_in + psp_pkg::ATAN_FINE[IDX];
    end
  end

  // token marking the live vector
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // vector register, passed on every cycle
  always_ff @(posedge clk_i) begin
    vec_q <= vec_d;
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;

endmodule

// File: rtl/psp_gain_mul.sv
`timescale 1ns / 1ps

module psp_gain_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [psp_pkg::XW-1:0] val_i,
  output logic                          done_o,
  output logic signed [psp_pkg::RW-1:0] res_o
);

  typedef enum logic [3:0] {
    G_IDLE = 4'b0001,
    G_LO   = 4'b0010,
    G_HI   = 4'b0100,
    G_RND  = 4'b1000
  } gstate_e;

  gstate_e                               state_q, state_d;
  logic signed [psp_pkg::XW-1:0]         val_q;
  logic signed [psp_pkg::ACC_W-1:0]      acc_q, acc_d;
  logic signed [psp_pkg::ACC_W-1:0]      rnd;
  logic signed [psp_pkg::OP_W-1:0]       op;
  logic signed [psp_pkg::PROD_W-1:0]     prod;
  logic signed [psp_pkg::RW-1:0]         res_q;
  logic                                  done_q;

  // operand select: unsigned low half first, then signed high half
  always_comb begin
    case (state_q)
      G_HI:    op = val_q[psp_pkg::XW-1:psp_pkg::LO_BITS];
      default: op = {{(psp_pkg::OP_W - psp_pkg::LO_BITS){1'b0}},
                     val_q[psp_pkg::LO_BITS-1:0]};
    endcase
  end

  assign prod = op * psp_pkg::GAIN_Q30;
  assign rnd  = acc_q + psp_pkg::ROUND_BIAS;

  // phase sequencer
  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    case (state_q)
      G_IDLE: if (start_i) state_d = G_LO;
      G_LO: begin
        acc_d   = psp_pkg::ACC_W'(prod);
        state_d = G_HI;
      end
      G_HI: begin
        acc_d   = acc_q + (psp_pkg::ACC_W'(prod) <<< psp_pkg::LO_BITS);
        state_d = G_RND;
      end
      G_RND:   state_d = G_IDLE;
      default: state_d = G_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= G_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == G_RND);
    end
  end

  // operand, accumulator and rounded result
  always_ff @(posedge clk_i) begin
    if (state_q == G_IDLE && start_i) begin
      val_q <= val_i;
    end
    acc_q <= acc_d;
    if (state_q == G_RND) begin
      res_q <= rnd[psp_pkg::ACC_W-1:psp_pkg::OUT_SHIFT];
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// File: rtl/planar_step_pose_integrator.sv
`timescale 1ns / 1ps

// channel   direction  handshake                 payload
// in        input      in_valid_i / in_ready_o   first_step_i step_dx_i step_dy_i step_turn_i
// out       output     out_valid_o / out_ready_i pos_x_o pos_y_o heading_o
//
// a request passes from acceptance through the fold, the cordic chain of ROTATE_ITERATIONS
// cells, the shared-multiplier gain phases (low half, high half, round), the entry to
// the write stage and the write. one request is in flight at a time; the next is
// accepted the cycle after the write.
// reset clears the pose to the origin with zero heading.
// a stalled output holds the write stage until the output register frees.

module planar_step_pose_integrator #(
  parameter int ROTATE_ITERATIONS = 16,
  parameter int POSITION_WIDTH    = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               first_step_i,
  input  logic signed [15:0] step_dx_i,
  input  logic signed [15:0] step_dy_i,
  input  logic signed [16:0] step_turn_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [16:0] heading_o
);

  localparam int N  = ROTATE_ITERATIONS;
  localparam int PW = POSITION_WIDTH;
  localparam int SW = PW + 1;
  localparam int EW = (PW > 32) ? PW : 32;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FOLD  = 5'b00010,
    S_ROT   = 5'b00100,
    S_GAIN  = 5'b01000,
    S_WRITE = 5'b10000
  } state_e;

  state_e                          state_q, state_d;
  logic                            in_acc;
  logic                            out_free;
  logic                            first_q;
  logic signed [15:0]              dx_q, dy_q;
  logic signed [16:0]              rot_q, head_q;
  logic signed [16:0]              rot_base, head_base;
  logic signed [17:0]              ra, hs;
  logic signed [16:0]              rot_d, head_d;
  logic signed [psp_pkg::ZW-1:0]   z0;
  logic signed [psp_pkg::XW-1:0]   x0, y0;
  psp_pkg::rot_vec_t               link [N+1];
  logic [N:0]                      vld;
  logic                            done_x, done_y;
  logic signed [psp_pkg::RW-1:0]   rx, ry;
  logic signed [PW-1:0]            world_x_q, world_y_q;
  logic signed [PW-1:0]            base_x, base_y;
  logic signed [PW-1:0]            new_x, new_y;
  logic signed [31:0]              pos_x_q, pos_y_q;
  logic signed [16:0]              heading_q;
  logic                            out_valid_q;

  function automatic logic signed [PW-1:0] sat_pos(input logic signed [SW-1:0] s);
    logic signed [PW-1:0] r;
    if (s[SW-1] != s[SW-2]) begin
      r = s[SW-1] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
    end else begin
      r = s[PW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] clamp_out(input logic signed [PW-1:0] w);
    logic signed [EW-1:0] e;
    logic signed [31:0]   r;
    e = EW'(w);
    if (e > EW'(32'sh7fffffff)) begin
      r = 32'sh7fffffff;
    end else if (e < EW'(32'sh80000000)) begin
      r = 32'sh80000000;
    end else begin
      r = 32'(e);
    end
    return r;
  endfunction

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // rotation angle wrap and truncating heading remainder
  assign rot_base  = first_step_i ? 17'sd0 : rot_q;
  assign head_base = first_step_i ? 17'sd0 : head_q;
  assign ra        = 18'(rot_base) + 18'(step_turn_i);
  assign hs        = 18'(head_base) + 18'(step_turn_i);

  always_comb begin
    if (ra >= psp_pkg::HALF_TURN) begin
      rot_d = 17'(ra - psp_pkg::FULL_TURN);
    end else if (ra < -psp_pkg::HALF_TURN) begin
      rot_d = 17'(ra + psp_pkg::FULL_TURN);
    end else begin
      rot_d = 17'(ra);
    end
  end

  always_comb begin
    if (hs >= psp_pkg::FULL_TURN) begin
      head_d = 17'(hs - psp_pkg::FULL_TURN);
    end else if (hs >= psp_pkg::HALF_TURN) begin
      head_d = 17'(hs - psp_pkg::HALF_TURN);
    end else if (hs <= -psp_pkg::FULL_TURN) begin
      head_d = 17'(hs + psp_pkg::FULL_TURN);
    end else if (hs <= -psp_pkg::HALF_TURN) begin
      head_d = 17'(hs + psp_pkg::HALF_TURN);
    end else begin
      head_d = 17'(hs);
    end
  end

  // scale into cordic units and fold into +-90 degrees
  always_comb begin
    z0 = $signed({rot_q, 8'd0});
    x0 = psp_pkg::XW'($signed({dx_q, 14'd0}));
    y0 = psp_pkg::XW'($signed({dy_q, 14'd0}));
    link[0].x = x0;
    link[0].y = y0;
    link[0].z = z0;
    if (z0 > psp_pkg::QUARTER_FINE) begin
      link[0].x = -x0;
      link[0].y = -y0;
      link[0].z = z0 - psp_pkg::HALF_FINE;
    end else if (z0 < -psp_pkg::QUARTER_FINE) begin
      link[0].x = -x0;
      link[0].y = -y0;
      link[0].z = z0 + psp_pkg::HALF_FINE;
    end
  end

  assign vld[0] = (state_q == S_FOLD);

  // chain of micro-rotation cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    psp_cordic_cell #(
      .IDX(i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(vld[i]),
      .vec_i  (link[i]),
      .valid_o(vld[i+1]),
      .vec_o  (link[i+1])
    );
  end

  // gain compensation and rescale
  psp_gain_mul u_gain_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(vld[N]),
    .val_i  (link[N].x),
    .done_o (done_x),
    .res_o  (rx)
  );

  psp_gain_mul u_gain_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(vld[N]),
    .val_i  (link[N].y),
    .done_o (done_y),
    .res_o  (ry)
  );

  // saturating world position update
  assign base_x = first_q ? '0 : world_x_q;
  assign base_y = first_q ? '0 : world_y_q;
  assign new_x  = sat_pos(SW'(base_x) + SW'(rx));
  assign new_y  = sat_pos(SW'(base_y) + SW'(ry));

  // request sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_acc) state_d = S_FOLD;
      S_FOLD:  state_d = S_ROT;
      S_ROT:   if (vld[N]) state_d = S_GAIN;
      S_GAIN:  if (done_x && done_y) state_d = S_WRITE;
      S_WRITE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control and pose state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      rot_q       <= '0;
      head_q      <= '0;
      world_x_q   <= '0;
      world_y_q   <= '0;
      first_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        rot_q   <= rot_d;
        head_q  <= head_d;
        first_q <= first_step_i;
      end
      if (state_q == S_WRITE && out_free) begin
        world_x_q   <= new_x;
        world_y_q   <= new_y;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request payload and output register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dx_q <= step_dx_i;
      dy_q <= step_dy_i;
    end
    if (state_q == S_WRITE && out_free) begin
      pos_x_q   <= clamp_out(new_x);
      pos_y_q   <= clamp_out(new_y);
      heading_q <= head_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = pos_x_q;
  assign pos_y_o     = pos_y_q;
  assign heading_o   = heading_q;

  // at most one vector travels the chain
  a_chain_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(vld))
    else $error("more than one vector in the cordic chain");

  // chain delivers only while the sequencer waits for it
  a_chain_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld[N] |-> state_q == S_ROT)
    else $error("cordic chain finished outside rotate phase");

  // both gain units finish together
  a_gain_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_x == done_y)
    else $error("gain units out of step");

  // a write always presents a result next cycle
  a_write_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE && out_free) |=> out_valid_o)
    else $error("result write lost");

  // heading stays within the half-turn remainder
  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (heading_o <= 17'sd46079 && heading_o >= -17'sd46079))
    else $error("heading out of range");

endmodule
